FILE: design/ssmc_pkg.sv
// Shared constants, class codes and helper functions of the matting cost block.
`default_nettype none
package ssmc_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_SAMPLES  = 32;
  localparam int ALPHA_LEVELS = 11;
  localparam int ALPHA_D      = ALPHA_LEVELS - 1;
  localparam int BEST_KEPT    = 10;
  localparam int UNIQ_THR     = 3;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int LIST_AW     = $clog2(MAX_SAMPLES);
  localparam int TOTAL_W     = $clog2(MAX_SAMPLES + 1);

  localparam int ERR_W   = 25;
  localparam int SQ_IN_W = 34;
  localparam int SQ_OUT_W = SQ_IN_W / 2;

  // Reciprocal division: q = (v * floor(2^DIV_SHIFT / d)) >> DIV_SHIFT, then one correction.
  localparam int DIV_SHIFT = 27;
  localparam int DIV_PAIR  = ALPHA_D * BEST_KEPT;
  localparam logic [23:0] RECIP_D    = 24'((64'd1 << DIV_SHIFT) / ALPHA_D);
  localparam logic [23:0] RECIP_PAIR = 24'((64'd1 << DIV_SHIFT) / DIV_PAIR);

  localparam logic [1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLS_BG      = 2'd1;
  localparam logic [1:0] CLS_FG      = 2'd2;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;
  localparam logic [1:0] CFG_COST_LIMIT   = 2'd3;

  typedef logic [23:0] color_t;
  typedef logic [ERR_W-1:0] err_t;

  function automatic logic [1:0] trimap_class(input logic [7:0] t);
    logic [1:0] k;
    if (t == 8'd0) begin
      k = CLS_BG;
    end else if (t == 8'd255 || t == 8'd2) begin
      k = CLS_FG;
    end else begin
      k = CLS_UNKNOWN;
    end
    return k;
  endfunction

  function automatic logic [9:0] l1_dist(input color_t p, input color_t q);
    logic [9:0] s;
    s = '0;
    for (int c = 0; c < 3; c++) begin
      if (p[8*c +: 8] > q[8*c +: 8]) begin
        s = s + 10'(p[8*c +: 8] - q[8*c +: 8]);
      end else begin
        s = s + 10'(q[8*c +: 8] - p[8*c +: 8]);
      end
    end
    return s;
  endfunction

  // D*pix - a*fg - (D-a)*bg for one channel.
  function automatic logic signed [13:0] blend_err(input logic [7:0] p, input logic [7:0] f,
                                                   input logic [7:0] b, input logic [3:0] a);
    logic [11:0] tp;
    logic [11:0] tf;
    logic [11:0] tb;
    tp = 12'(p) * 12'(ALPHA_D);
    tf = 12'(f) * 12'(a);
    tb = 12'(b) * 12'(4'(ALPHA_D) - a);
    return signed'({2'b00, tp}) - signed'({2'b00, tf}) - signed'({2'b00, tb});
  endfunction

endpackage
`default_nettype wire

FILE: design/ssmc_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
`default_nettype none
interface ssmc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] pos_x;
  logic [5:0] pos_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] trimap;
  modport source (output valid, req_type, pos_x, pos_y, red, green, blue, trimap,
                  input ready);
  modport sink (input valid, req_type, pos_x, pos_y, red, green, blue, trimap,
                output ready);
endinterface

interface ssmc_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  alpha_level;
  logic [13:0] cost;
  logic [1:0]  pixel_class;
  logic        search_short;
  logic        last;
  modport source (output valid, alpha_level, cost, pixel_class, search_short, last,
                  input ready);
  modport sink (input valid, alpha_level, cost, pixel_class, search_short, last,
                output ready);
endinterface

interface ssmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [13:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

FILE: design/spiral_sample_matting_cost.sv
// Top level of the spiral-sampling matting cost block.
//
// A load request writes one pixel into the 4096-entry pixel memory and gives no result.
// A query request reads its pixel and then returns eleven results, one per alpha level.
// A known pixel passes per level through S_KN0, the divide states and S_EMIT. An unknown
// pixel first walks square rings around itself: every ring position is visited in
// S_VISIT, an in-image position takes its memory read in S_VRD, each ring ends with a
// check in S_RING, and each compared entry of a sample list takes a step of S_DUP,
// since the pixel memory and the two sample memories each have one read port. Each
// alpha level then scores all bg x fg sample pairs through a four-stage pipeline at one
// pair per cycle, followed by ten square roots and a divide through S_DV0, S_DV1 and
// S_DV2. New requests are taken only while no query is in work; the last results may
// still sit in the output register.
`default_nettype none
module spiral_sample_matting_cost import ssmc_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  ssmc_req_if.sink   req,
  ssmc_res_if.source res,
  ssmc_cfg_if.sink   cfg
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_QRD      = 5'd1;
  localparam logic [4:0] S_RING     = 5'd2;
  localparam logic [4:0] S_VISIT    = 5'd3;
  localparam logic [4:0] S_VRD      = 5'd4;
  localparam logic [4:0] S_DUP      = 5'd5;
  localparam logic [4:0] S_SC_INIT  = 5'd6;
  localparam logic [4:0] S_SC_RUN   = 5'd7;
  localparam logic [4:0] S_SQ_START = 5'd8;
  localparam logic [4:0] S_SQ_WAIT  = 5'd9;
  localparam logic [4:0] S_KN0      = 5'd10;
  localparam logic [4:0] S_DV0      = 5'd11;
  localparam logic [4:0] S_DV1      = 5'd12;
  localparam logic [4:0] S_DV2      = 5'd13;
  localparam logic [4:0] S_EMIT     = 5'd14;

  localparam logic [1:0] MODE_KNOWN = 2'd0;
  localparam logic [1:0] MODE_SAT   = 2'd1;
  localparam logic [1:0] MODE_SCORE = 2'd2;

  localparam int KEPT_AW = $clog2(BEST_KEPT);
  localparam int SUM_W   = SQ_OUT_W + $clog2(BEST_KEPT) + 1;

  // Configuration registers.
  logic [6:0]  image_width;
  logic [6:0]  image_height;
  logic [5:0]  sample_count;
  logic [13:0] cost_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 7'd64;
      image_height <= 7'd64;
      sample_count <= 6'd8;
      cost_limit   <= 14'd480;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.addr)
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data[6:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg.data[6:0];
        CFG_SAMPLE_COUNT: sample_count <= cfg.data[5:0];
        CFG_COST_LIMIT:   cost_limit   <= cfg.data;
        default: ;
      endcase
    end
  end

  logic [6:0]          w_eff;
  logic [6:0]          h_eff;
  logic [TOTAL_W-1:0]  cap;

  assign w_eff = (image_width == 7'd0) ? 7'd1 :
                 (image_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height == 7'd0) ? 7'd1 :
                 (image_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : image_height;
  assign cap   = (sample_count < 6'd2) ? TOTAL_W'(2) :
                 (sample_count > 6'(MAX_SAMPLES)) ? TOTAL_W'(MAX_SAMPLES)
                                                  : TOTAL_W'(sample_count);

  // Sequencer state.
  logic [4:0]               state;
  logic [1:0]               mode;
  logic [5:0]               qx;
  logic [5:0]               qy;
  logic [25:0]              pix;
  logic [1:0]               cls;
  logic                     sshort;
  logic [3:0]               alpha;
  logic signed [7:0]        rmax;
  logic signed [7:0]        r;
  logic signed [7:0]        di;
  logic [1:0]               side;
  logic                     ring_end;
  logic [TOTAL_W-1:0]       bg_total;
  logic [TOTAL_W-1:0]       fg_total;
  logic [LIST_AW-1:0]       dup_i;
  logic                     dup_bg;
  color_t                   col;
  logic [LIST_AW-1:0]       pb;
  logic [LIST_AW-1:0]       pf;
  logic                     issuing;
  logic                     v1;
  logic                     v2;
  logic                     v3;
  err_t                     best [BEST_KEPT];
  logic [KEPT_AW-1:0]       kj;
  logic [SUM_W-1:0]         sq_sum;
  logic [20:0]              dv_val;
  logic                     dv_pair;
  logic [44:0]              dv_prod;
  logic [20:0]              dv_q;
  logic [13:0]              cost_r;

  // Pixel memory.
  logic [25:0]          pix_mem [STORE_DEPTH];
  logic                 st_we;
  logic [STORE_AW-1:0]  st_raddr;
  logic [25:0]          st_q;

  // Sample list memories.
  color_t               bg_mem [MAX_SAMPLES];
  color_t               fg_mem [MAX_SAMPLES];
  logic                 bg_we;
  logic                 fg_we;
  color_t               list_wdata;
  logic [LIST_AW-1:0]   bg_raddr;
  logic [LIST_AW-1:0]   fg_raddr;
  color_t               bg_q;
  color_t               fg_q;

  // Ring geometry.
  logic signed [7:0] sx;
  logic signed [7:0] sy;
  logic signed [7:0] w8;
  logic signed [7:0] h8;
  logic signed [7:0] px;
  logic signed [7:0] py;
  logic signed [7:0] m_a;
  logic signed [7:0] m_b;
  logic signed [7:0] rmax_next;
  logic              in_image;
  logic              last_pos;

  assign sx = signed'({2'b00, qx});
  assign sy = signed'({2'b00, qy});
  assign w8 = signed'({1'b0, w_eff});
  assign h8 = signed'({1'b0, h_eff});

  always_comb begin
    m_a = ((w8 - 8'sd1 - sx) > sx) ? (w8 - 8'sd1 - sx) : sx;
    m_b = ((h8 - 8'sd1 - sy) > sy) ? (h8 - 8'sd1 - sy) : sy;
    rmax_next = (m_a > m_b) ? m_a : m_b;
  end

  always_comb begin
    case (side)
      2'd0: begin px = sx + di; py = sy - r;  end
      2'd1: begin px = sx + r;  py = sy + di; end
      2'd2: begin px = sx - di; py = sy + r;  end
      default: begin px = sx - r; py = sy - di; end
    endcase
  end

  assign in_image = (px >= 8'sd0) && (py >= 8'sd0) && (px < w8) && (py < h8);
  assign last_pos = (side == 2'd3) && (di == r - 8'sd1);

  // Sample decisions.
  logic [1:0]          vcls;
  logic                take_bg;
  logic                take_fg;
  color_t              dup_q;
  logic [TOTAL_W-1:0]  dup_total;
  logic                dup_close;
  logic                dup_last;
  logic [11:0]         pair_count;
  logic                searched_out;

  assign vcls      = st_q[25:24];
  assign take_bg   = (vcls == CLS_BG) && (bg_total < cap);
  assign take_fg   = (vcls == CLS_FG) && (fg_total < cap);
  assign dup_q     = dup_bg ? bg_q : fg_q;
  assign dup_total = dup_bg ? bg_total : fg_total;
  assign dup_close = l1_dist(dup_q, col) < 10'(UNIQ_THR);
  assign dup_last  = (TOTAL_W'(dup_i) + 1'b1) == dup_total;
  assign pair_count = 12'(bg_total) * 12'(fg_total);
  assign searched_out = (bg_total >= cap) || (fg_total >= cap);

  assign bg_we = ((state == S_VRD) && take_bg && (bg_total == '0)) ||
                 ((state == S_DUP) && dup_bg && !dup_close && dup_last);
  assign fg_we = ((state == S_VRD) && take_fg && (fg_total == '0)) ||
                 ((state == S_DUP) && !dup_bg && !dup_close && dup_last);
  assign list_wdata = (state == S_VRD) ? st_q[23:0] : col;

  always_comb begin
    bg_raddr = '0;
    fg_raddr = '0;
    if (state == S_SC_RUN) begin
      bg_raddr = pb;
      fg_raddr = pf;
    end else if (state == S_DUP) begin
      bg_raddr = dup_i + 1'b1;
      fg_raddr = dup_i + 1'b1;
    end
  end

  assign st_we    = (state == S_IDLE) && req.valid && !req.req_type;
  assign st_raddr = (state == S_IDLE) ? {req.pos_y, req.pos_x} : {py[5:0], px[5:0]};

  always_ff @(posedge clk) begin
    if (st_we) begin
      pix_mem[{req.pos_y, req.pos_x}] <= {trimap_class(req.trimap), req.blue, req.green,
                                          req.red};
    end
    st_q <= pix_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_mem[bg_total[LIST_AW-1:0]] <= list_wdata;
    end
    bg_q <= bg_mem[bg_raddr];
  end

  always_ff @(posedge clk) begin
    if (fg_we) begin
      fg_mem[fg_total[LIST_AW-1:0]] <= list_wdata;
    end
    fg_q <= fg_mem[fg_raddr];
  end

  assign req.ready = (state == S_IDLE);

  // Pair scoring pipeline: read, blend error, squared sum, insertion.
  logic signed [13:0] t_r;
  logic signed [13:0] t_g;
  logic signed [13:0] t_b;
  logic signed [27:0] sq_r;
  logic signed [27:0] sq_g;
  logic signed [27:0] sq_b;
  err_t               e_reg;
  err_t               best_next [BEST_KEPT];

  assign sq_r = t_r * t_r;
  assign sq_g = t_g * t_g;
  assign sq_b = t_b * t_b;

  always_ff @(posedge clk) begin
    if (v1) begin
      t_r <= blend_err(pix[7:0],   fg_q[7:0],   bg_q[7:0],   alpha);
      t_g <= blend_err(pix[15:8],  fg_q[15:8],  bg_q[15:8],  alpha);
      t_b <= blend_err(pix[23:16], fg_q[23:16], bg_q[23:16], alpha);
    end
    if (v2) begin
      e_reg <= ERR_W'(sq_r) + ERR_W'(sq_g) + ERR_W'(sq_b);
    end
  end

  // The kept list stays sorted; a new error shifts larger entries down by one.
  always_comb begin
    for (int j = 0; j < BEST_KEPT; j++) begin
      if (e_reg < best[j]) begin
        if (j == 0) begin
          best_next[j] = e_reg;
        end else if (e_reg >= best[j-1]) begin
          best_next[j] = e_reg;
        end else begin
          best_next[j] = best[j-1];
        end
      end else begin
        best_next[j] = best[j];
      end
    end
  end

  // Square root unit.
  logic                sq_start;
  logic                sq_done;
  logic [SQ_OUT_W-1:0] sq_root;

  assign sq_start = (state == S_SQ_START);

  ssmc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (SQ_IN_W'({best[kj], 8'h00})),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Divide by a constant through the reciprocal, then one correction step.
  logic [20:0] dv_rem;
  logic [20:0] dv_fin;
  logic [6:0]  dv_div;

  assign dv_div = dv_pair ? 7'(DIV_PAIR) : 7'(ALPHA_D);
  assign dv_rem = dv_val - 21'(dv_q * 21'(dv_div));
  assign dv_fin = (dv_rem >= 21'(dv_div)) ? dv_q + 21'd1 : dv_q;

  logic emit_load;
  logic [3:0] kfac;
  assign emit_load = (state == S_EMIT) && (!res.valid || res.ready);
  assign kfac = (cls == CLS_BG) ? alpha : 4'(ALPHA_D) - alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= MODE_KNOWN;
      issuing  <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      bg_total <= '0;
      fg_total <= '0;
      for (int j = 0; j < BEST_KEPT; j++) begin
        best[j] <= '1;
      end
    end else begin
      v1 <= (state == S_SC_RUN) && issuing;
      v2 <= v1;
      v3 <= v2;
      if (v3) begin
        best <= best_next;
      end
      if (bg_we) begin
        bg_total <= bg_total + 1'b1;
      end
      if (fg_we) begin
        fg_total <= fg_total + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.req_type) begin
            qx    <= req.pos_x;
            qy    <= req.pos_y;
            state <= S_QRD;
          end
        end
        S_QRD: begin
          pix    <= st_q;
          cls    <= (st_q[25:24] == 2'd3) ? CLS_UNKNOWN : st_q[25:24];
          sshort <= 1'b0;
          alpha  <= '0;
          if (st_q[25:24] == CLS_BG || st_q[25:24] == CLS_FG) begin
            mode  <= MODE_KNOWN;
            state <= S_KN0;
          end else begin
            rmax     <= rmax_next;
            r        <= 8'sd1;
            bg_total <= '0;
            fg_total <= '0;
            state    <= S_RING;
          end
        end
        S_RING: begin
          if (searched_out) begin
            if (pair_count < 12'(BEST_KEPT)) begin
              mode   <= MODE_SAT;
              cost_r <= cost_limit;
              state  <= S_EMIT;
            end else begin
              mode  <= MODE_SCORE;
              state <= S_SC_INIT;
            end
          end else if (r > rmax) begin
            sshort <= 1'b1;
            mode   <= MODE_SAT;
            cost_r <= cost_limit;
            state  <= S_EMIT;
          end else begin
            di    <= -r;
            side  <= 2'd0;
            state <= S_VISIT;
          end
        end
        S_VISIT: begin
          ring_end <= last_pos;
          side     <= side + 2'd1;
          if (side == 2'd3) begin
            di <= di + 8'sd1;
          end
          if (last_pos) begin
            r <= r + 8'sd1;
          end
          if (in_image) begin
            state <= S_VRD;
          end else if (last_pos) begin
            state <= S_RING;
          end
        end
        S_VRD: begin
          col    <= st_q[23:0];
          dup_i  <= '0;
          dup_bg <= take_bg;
          if ((take_bg && bg_total != '0) || (take_fg && fg_total != '0)) begin
            state <= S_DUP;
          end else begin
            state <= ring_end ? S_RING : S_VISIT;
          end
        end
        S_DUP: begin
          if (dup_close || dup_last) begin
            state <= ring_end ? S_RING : S_VISIT;
          end else begin
            dup_i <= dup_i + 1'b1;
          end
        end
        S_SC_INIT: begin
          for (int j = 0; j < BEST_KEPT; j++) begin
            best[j] <= '1;
          end
          pb      <= '0;
          pf      <= '0;
          issuing <= 1'b1;
          state   <= S_SC_RUN;
        end
        S_SC_RUN: begin
          if (issuing) begin
            if (pf == LIST_AW'(fg_total - 1'b1)) begin
              pf <= '0;
              pb <= pb + 1'b1;
              if (pb == LIST_AW'(bg_total - 1'b1)) begin
                issuing <= 1'b0;
              end
            end else begin
              pf <= pf + 1'b1;
            end
          end else if (!v1 && !v2 && !v3) begin
            kj     <= '0;
            sq_sum <= '0;
            state  <= S_SQ_START;
          end
        end
        S_SQ_START: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (sq_done) begin
            sq_sum <= sq_sum + SUM_W'(sq_root);
            if (kj == KEPT_AW'(BEST_KEPT - 1)) begin
              dv_val  <= 21'(sq_sum + SUM_W'(sq_root)) + 21'(DIV_PAIR / 2);
              dv_pair <= 1'b1;
              state   <= S_DV0;
            end else begin
              kj    <= kj + 1'b1;
              state <= S_SQ_START;
            end
          end
        end
        S_KN0: begin
          dv_val  <= 21'(18'(kfac) * 18'(cost_limit)) + 21'(ALPHA_D / 2);
          dv_pair <= 1'b0;
          state   <= S_DV0;
        end
        S_DV0: begin
          dv_prod <= 45'(dv_val) * 45'(dv_pair ? RECIP_PAIR : RECIP_D);
          state   <= S_DV1;
        end
        S_DV1: begin
          dv_q  <= 21'(dv_prod >> DIV_SHIFT);
          state <= S_DV2;
        end
        S_DV2: begin
          cost_r <= (dv_fin > 21'(cost_limit)) ? cost_limit : dv_fin[13:0];
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            if (alpha == 4'(ALPHA_D)) begin
              state <= S_IDLE;
            end else begin
              alpha <= alpha + 4'd1;
              case (mode)
                MODE_KNOWN: state <= S_KN0;
                MODE_SCORE: state <= S_SC_INIT;
                default:    state <= S_EMIT;
              endcase
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  logic        out_valid;
  logic [3:0]  out_alpha;
  logic [13:0] out_cost;
  logic [1:0]  out_cls;
  logic        out_short;
  logic        out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_alpha <= alpha;
      out_cost  <= cost_r;
      out_cls   <= cls;
      out_short <= sshort;
      out_last  <= (alpha == 4'(ALPHA_D));
    end
  end

  assign res.valid        = out_valid;
  assign res.alpha_level  = out_alpha;
  assign res.cost         = out_cost;
  assign res.pixel_class  = out_cls;
  assign res.search_short = out_short;
  assign res.last         = out_last;

endmodule
`default_nettype wire

FILE: design/ssmc_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module ssmc_isqrt import ssmc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SQ_IN_W-1:0]  value,
  output logic                     done,
  output logic [SQ_OUT_W-1:0]      root
);

  localparam int REM_W = SQ_OUT_W + 2;
  localparam int CNT_W = $clog2(SQ_OUT_W + 1);

  logic [SQ_IN_W-1:0]  rad;
  logic [REM_W-1:0]    rem;
  logic [CNT_W-1:0]    cnt;
  logic                run;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                fits;

  assign rem_sh = {rem, rad[SQ_IN_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && !start && (cnt == CNT_W'(SQ_OUT_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQ_OUT_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= value;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      rad <= {rad[SQ_IN_W-3:0], 2'b00};
      if (fits) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(rem_sh);
        root <= {root[SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/ssmc_chk.sv
// Port-level checks of the matting cost block and their binding to the top level.
`default_nettype none
module ssmc_chk import ssmc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [3:0] res_alpha_level,
  input wire logic [1:0] res_pixel_class,
  input wire logic       res_search_short,
  input wire logic       res_last
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_last_level: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_alpha_level == 4'(ALPHA_D))
    else $error("last flag not on the final alpha level");

  a_known_short: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_pixel_class != CLS_UNKNOWN |-> !res_search_short)
    else $error("known pixel flagged as short search");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !req_ready)
    else $error("new request taken while a query is still in work");

endmodule

bind spiral_sample_matting_cost ssmc_chk u_ssmc_chk (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_alpha_level  (res.alpha_level),
  .res_pixel_class  (res.pixel_class),
  .res_search_short (res.search_short),
  .res_last         (res.last)
);
`default_nettype wire

FILE: tb/spiral_sample_matting_cost_test.sv
// Self-checking testbench of the matting cost block: loads pixels, queries costs, checks results.
`default_nettype none
module spiral_sample_matting_cost_test;
  import ssmc_pkg::*;

  localparam int HOLD_CYCLES = 2000;
  localparam int STALL_LIMIT = 300000;
  localparam int SETTLE = 20;
  localparam int IMG = 8;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] t;
  } pixel_req_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [13:0] cost;
    logic [1:0]  cls;
    logic        short_search;
    logic        last;
  } cost_res_t;

  logic clk;
  logic rst;
  ssmc_req_if req_ch();
  ssmc_res_if res_ch();
  ssmc_cfg_if cfg_ch();

  spiral_sample_matting_cost i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  // Mirror of the block's state.
  logic [25:0] image_mem[STORE_DEPTH];
  color_t bg_colors[MAX_SAMPLES];
  color_t fg_colors[MAX_SAMPLES];
  int bg_found;
  int fg_found;
  int width_reg = 64;
  int height_reg = 64;
  int samples_reg = 8;
  int limit_reg = 480;

  cost_res_t expected_costs[$];
  int errors = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int results_seen = 0;
  int shorts_seen = 0;
  bit idle_on = 1'b1;
  bit hold_results = 1'b0;
  color_t palette[8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int color_dist(color_t p, color_t q);
    int s;
    int d;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      d = int'(p[8*c +: 8]) - int'(q[8*c +: 8]);
      s += d < 0 ? -d : d;
    end
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void take_sample(bit is_fg, color_t col, int cap);
    if (is_fg) begin
      if (fg_found >= cap) return;
      for (int i = 0; i < fg_found; i++)
        if (color_dist(fg_colors[i], col) < UNIQ_THR) return;
      fg_colors[fg_found] = col;
      fg_found++;
    end else begin
      if (bg_found >= cap) return;
      for (int i = 0; i < bg_found; i++)
        if (color_dist(bg_colors[i], col) < UNIQ_THR) return;
      bg_colors[bg_found] = col;
      bg_found++;
    end
  endfunction

  function automatic void ring_visit(int x, int y, int w, int h, int cap);
    logic [25:0] p;
    if (x < 0 || y < 0 || x >= w || y >= h) return;
    p = image_mem[y * MAX_WIDTH + x];
    if (p[25:24] == CLS_BG) take_sample(1'b0, p[23:0], cap);
    else if (p[25:24] == CLS_FG) take_sample(1'b1, p[23:0], cap);
  endfunction

  // Rounded mean of sqrt(256*e) over the best blend errors e of one level, divided by ALPHA_D.
  function automatic int blend_cost(color_t pix, int a);
    longint unsigned best[BEST_KEPT];
    longint unsigned e;
    longint unsigned tmp;
    longint unsigned sum;
    longint unsigned q;
    longint t;
    for (int j = 0; j < BEST_KEPT; j++) best[j] = 64'hFFFF_FFFF;
    for (int bi = 0; bi < bg_found; bi++) begin
      for (int fi = 0; fi < fg_found; fi++) begin
        e = 0;
        for (int c = 0; c < 3; c++) begin
          t = longint'(ALPHA_D) * pix[8*c +: 8] - longint'(a) * fg_colors[fi][8*c +: 8]
              - longint'(ALPHA_D - a) * bg_colors[bi][8*c +: 8];
          e += t * t;
        end
        if (e < best[BEST_KEPT-1]) begin
          best[BEST_KEPT-1] = e;
          for (int j = BEST_KEPT - 1; j > 0; j--) begin
            if (best[j] < best[j-1]) begin
              tmp = best[j-1];
              best[j-1] = best[j];
              best[j] = tmp;
            end
          end
        end
      end
    end
    sum = 0;
    for (int j = 0; j < BEST_KEPT; j++) sum += int_sqrt(best[j] << 8);
    q = (sum + ALPHA_D * BEST_KEPT / 2) / (ALPHA_D * BEST_KEPT);
    return q > limit_reg ? limit_reg : int'(q);
  endfunction

  function automatic logic [1:0] class_of(logic [7:0] t);
    if (t == 8'd0) return CLS_BG;
    if (t == 8'd255 || t == 8'd2) return CLS_FG;
    return CLS_UNKNOWN;
  endfunction

  // Updates the mirrored store, or queues the eleven expected costs of a query.
  function automatic void predict_costs(pixel_req_t rq);
    logic [25:0] pix;
    logic [1:0] cls;
    bit sshort;
    int x;
    int y;
    int w;
    int h;
    int cap;
    int rmax;
    int rr;
    int cost;
    cost_res_t er;
    x = rq.x;
    y = rq.y;
    if (rq.kind == REQ_LOAD) begin
      image_mem[y * MAX_WIDTH + x] = {class_of(rq.t), rq.b, rq.g, rq.r};
      return;
    end
    pix = image_mem[y * MAX_WIDTH + x];
    cls = pix[25:24] == 2'd3 ? CLS_UNKNOWN : pix[25:24];
    sshort = 1'b0;
    if (cls == CLS_UNKNOWN) begin
      w = clampi(width_reg, 1, MAX_WIDTH);
      h = clampi(height_reg, 1, MAX_HEIGHT);
      cap = clampi(samples_reg, 2, MAX_SAMPLES);
      rmax = x;
      if (w - 1 - x > rmax) rmax = w - 1 - x;
      if (y > rmax) rmax = y;
      if (h - 1 - y > rmax) rmax = h - 1 - y;
      bg_found = 0;
      fg_found = 0;
      rr = 1;
      while (bg_found < cap && fg_found < cap) begin
        if (rr > rmax) begin
          sshort = 1'b1;
          break;
        end
        for (int di = -rr; di < rr; di++) begin
          ring_visit(x + di, y - rr, w, h, cap);
          ring_visit(x + rr, y + di, w, h, cap);
          ring_visit(x - di, y + rr, w, h, cap);
          ring_visit(x - rr, y - di, w, h, cap);
        end
        rr++;
      end
    end
    for (int a = 0; a < ALPHA_LEVELS; a++) begin
      if (cls == CLS_BG) cost = (a * limit_reg + ALPHA_D / 2) / ALPHA_D;
      else if (cls == CLS_FG) cost = ((ALPHA_D - a) * limit_reg + ALPHA_D / 2) / ALPHA_D;
      else if (sshort || bg_found * fg_found < BEST_KEPT) cost = limit_reg;
      else cost = blend_cost(pix[23:0], a);
      er.level = 4'(a);
      er.cost = 14'(cost);
      er.cls = cls;
      er.short_search = sshort;
      er.last = a == ALPHA_LEVELS - 1;
      expected_costs.push_back(er);
    end
  endfunction

  task automatic send_req(pixel_req_t rq);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    req_ch.req_type <= rq.kind;
    req_ch.pos_x <= rq.x;
    req_ch.pos_y <= rq.y;
    req_ch.red <= rq.r;
    req_ch.green <= rq.g;
    req_ch.blue <= rq.b;
    req_ch.trimap <= rq.t;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    predict_costs(rq);
    if (rq.kind == REQ_LOAD) loads_sent++;
    else queries_sent++;
  endtask

  task automatic load_pixel(int x, int y, color_t col, logic [7:0] t);
    send_req({REQ_LOAD, 6'(x), 6'(y), col[7:0], col[15:8], col[23:16], t});
  endtask

  task automatic query_pixel(int x, int y);
    send_req({REQ_QUERY, 6'(x), 6'(y), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom)});
  endtask

  function automatic color_t pick_color();
    color_t c;
    // Half the colors sit close to a small palette so that duplicates get dropped.
    if ($urandom_range(0, 1)) begin
      c = palette[$urandom_range(0, 7)];
      for (int i = 0; i < 3; i++)
        c[8*i +: 8] = 8'(c[8*i +: 8] + $urandom_range(0, 3));
      return c;
    end
    return color_t'($urandom);
  endfunction

  function automatic logic [7:0] pick_trimap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'd0;
      4, 5: return 8'd255;
      6, 7: return 8'd2;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (expected_costs.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    drain();
    cfg_ch.addr <= idx;
    cfg_ch.data <= 14'(value);
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_IMAGE_WIDTH: width_reg = value & 8'h7F;
      CFG_IMAGE_HEIGHT: height_reg = value & 8'h7F;
      CFG_SAMPLE_COUNT: samples_reg = value & 8'h3F;
      default: limit_reg = value & 16'h3FFF;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(int w, int h, int n, int lim);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_SAMPLE_COUNT, n);
    write_reg(CFG_COST_LIMIT, lim);
  endtask

  // Every entry of the corner square gets written once; images and rings stay inside it.
  task automatic fill_image();
    for (int y = 0; y < IMG; y++)
      for (int x = 0; x < IMG; x++)
        load_pixel(x, y, pick_color(), pick_trimap());
  endtask

  task automatic test_known_pixels();
    set_regs(IMG, IMG, 8, 16383);
    load_pixel(0, 0, 24'h000000, 8'd0);
    load_pixel(IMG - 1, IMG - 1, 24'hFFFFFF, 8'd255);
    load_pixel(5, 7, 24'h123456, 8'd2);
    query_pixel(0, 0);
    query_pixel(IMG - 1, IMG - 1);
    query_pixel(5, 7);
    write_reg(CFG_COST_LIMIT, 0);
    query_pixel(0, 0);
    query_pixel(IMG - 1, IMG - 1);
  endtask

  task automatic test_unknown_pixels();
    logic [7:0] codes[4] = '{8'd1, 8'd3, 8'd128, 8'd254};
    set_regs(IMG, IMG, 32, 480);
    for (int i = 0; i < 4; i++) begin
      load_pixel(2 + i, 3, color_t'($urandom), codes[i]);
      query_pixel(2 + i, 3);
    end
    write_reg(CFG_SAMPLE_COUNT, 2);
    query_pixel(3, 3);
  endtask

  task automatic test_image_edges();
    set_regs(2, 2, 32, 1000);
    load_pixel(0, 0, 24'hFF00FF, 8'd7);
    query_pixel(0, 0);
    // Outside the image the stored pixel is still used, and the rings stay inside.
    load_pixel(40, 40, 24'h00FF00, 8'd99);
    query_pixel(40, 40);
    set_regs(1, 1, 2, 300);
    query_pixel(0, 0);
  endtask

  task automatic test_backpressure();
    set_regs(IMG, IMG, 8, 480);
    hold_results = 1'b1;
    for (int i = 0; i < 10; i++) query_pixel($urandom_range(0, IMG - 1), $urandom_range(0, IMG - 1));
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 9) < 4)
        load_pixel($urandom_range(0, IMG - 1), $urandom_range(0, IMG - 1), pick_color(),
                   pick_trimap());
      else
        query_pixel($urandom_range(0, IMG - 1), $urandom_range(0, IMG - 1));
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) palette[i] = color_t'($urandom);
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.red = '0;
    req_ch.green = '0;
    req_ch.blue = '0;
    req_ch.trimap = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = CFG_IMAGE_WIDTH;
    cfg_ch.data = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    fill_image();
    test_known_pixels();
    test_unknown_pixels();
    test_image_edges();
    test_backpressure();
    set_regs(IMG, IMG, 32, 16383);
    test_random(12);
    set_regs($urandom_range(1, IMG), $urandom_range(1, IMG), $urandom_range(2, 12),
             $urandom_range(0, 16383));
    test_random(12);
    set_regs(IMG, IMG, 2, 200);
    test_random(12);
    set_regs($urandom_range(1, IMG), $urandom_range(1, IMG), $urandom_range(2, 32), 480);
    idle_on = 1'b0;
    test_random(12);
    drain();
    $display("Covered %0d loads and %0d queries, %0d results checked, %0d short searches.",
             loads_sent, queries_sent, results_seen, shorts_seen);
    if (errors == 0) begin
      $display("PASS spiral_sample_matting_cost");
    end else begin
      $display("FAIL spiral_sample_matting_cost");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off that backs the block up.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cost_res_t er;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_costs.size() == 0) begin
        errors++;
        $error("unexpected result, level %0d cost %0d", res_ch.alpha_level, res_ch.cost);
      end else begin
        er = expected_costs.pop_front();
        if (er.short_search && er.last) shorts_seen++;
        if (res_ch.alpha_level !== er.level) begin
          errors++;
          $error("alpha_level: expected %0d, got %0d", er.level, res_ch.alpha_level);
        end
        if (res_ch.cost !== er.cost) begin
          errors++;
          $error("cost: expected %0d, got %0d", er.cost, res_ch.cost);
        end
        if (res_ch.pixel_class !== er.cls) begin
          errors++;
          $error("pixel_class: expected %0d, got %0d", er.cls, res_ch.pixel_class);
        end
        if (res_ch.search_short !== er.short_search) begin
          errors++;
          $error("search_short: expected %0d, got %0d", er.short_search, res_ch.search_short);
        end
        if (res_ch.last !== er.last) begin
          errors++;
          $error("last: expected %0d, got %0d", er.last, res_ch.last);
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL spiral_sample_matting_cost");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire

FILE: sim.f
design/ssmc_pkg.sv
design/ssmc_if.sv
design/ssmc_isqrt.sv
design/spiral_sample_matting_cost.sv
design/ssmc_chk.sv
tb/spiral_sample_matting_cost_test.sv
